/* design/rc_arming_sequencer_top_assert.svh */
`ifndef RC_ARMING_SEQUENCER_TOP_ASSERT_SVH
`define RC_ARMING_SEQUENCER_TOP_ASSERT_SVH

// Check that a consequent holds in the same cycle as its antecedent
`define RCAS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define RCAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rcas_pkg.sv */
package rcas_pkg;

   // Stick scale: Q2.14, held in 18 bits for margin arithmetic
   localparam int STICK_W = 18;
   localparam logic signed [STICK_W-1:0] STICK_MIN = -18'sd16384;
   localparam logic signed [STICK_W-1:0] STICK_MAX = 18'sd16384;

   // Configuration register indexes
   localparam logic [1:0] REG_STICK_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_ARM_HOLD_MS     = 2'd1;
   localparam logic [1:0] REG_DISARM_HOLD_MS  = 2'd2;

   // Configuration reset values
   localparam logic [14:0] THRESHOLD_RESET   = 15'd1638;
   localparam logic [15:0] ARM_HOLD_RESET    = 16'd1000;
   localparam logic [15:0] DISARM_HOLD_RESET = 16'd1000;

   // Controller action codes
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_UPDATE = 2'd1;
   localparam logic [1:0] ACT_IDLE   = 2'd2;
   localparam logic [1:0] ACT_RESET  = 2'd3;

   // Flight mode codes
   localparam logic [1:0] MODE_INVALID = 2'd3;

   // Stage codes as seen on the result channel
   localparam logic [2:0] STAGE_WAIT_ARM      = 3'd1;
   localparam logic [2:0] STAGE_WAIT_THROTTLE = 3'd3;
   localparam logic [2:0] STAGE_RUNNING       = 3'd4;

   typedef struct packed {
      logic [14:0] stick_threshold;
      logic [15:0] arm_hold_ms;
      logic [15:0] disarm_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        frame_time_ms;
      logic signed [15:0] stick_roll;
      logic signed [15:0] stick_pitch;
      logic signed [15:0] stick_yaw;
      logic signed [15:0] stick_throttle;
      logic               kill_switch;
      logic               enable_switch;
      logic [1:0]         requested_mode;
      logic               status_ready;
      logic               rotors_armed;
      logic               prearm_ok;
      logic               mode_applicable;
   } frame_type;

   typedef struct packed {
      logic arm_gesture;
      logic disarm_gesture;
      logic thr_above;
   } gesture_type;

   typedef struct packed {
      logic       arm_request;
      logic       disarm_request;
      logic [1:0] controller_action;
      logic [1:0] active_mode;
      logic [2:0] stage_now;
   } result_type;

   // Gesture hold expired: elapsed time strictly above the hold time, modulo 2^32
   function automatic logic held_longer(logic [31:0] now, logic [31:0] start,
                                        logic [15:0] hold);
      logic [31:0] elapsed;
      elapsed = now - start;
      return elapsed > {16'd0, hold};
   endfunction

endpackage

/* design/rcas_csr.sv */
module rcas_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output rcas_pkg::cfg_type cfg
);

   rcas_pkg::cfg_type cfg_ff;
   rcas_pkg::cfg_type cfg_in;

   // Decode the write; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rcas_pkg::REG_STICK_THRESHOLD: cfg_in.stick_threshold = csr_wdata[14:0];
            rcas_pkg::REG_ARM_HOLD_MS:     cfg_in.arm_hold_ms     = csr_wdata;
            rcas_pkg::REG_DISARM_HOLD_MS:  cfg_in.disarm_hold_ms  = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_threshold <= rcas_pkg::THRESHOLD_RESET;
         cfg_ff.arm_hold_ms     <= rcas_pkg::ARM_HOLD_RESET;
         cfg_ff.disarm_hold_ms  <= rcas_pkg::DISARM_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/rcas_gesture.sv */
module rcas_gesture (
   input  rcas_pkg::frame_type   frame,
   input  logic [14:0]           stick_threshold,
   output rcas_pkg::gesture_type gesture
);

   logic signed [rcas_pkg::STICK_W-1:0] th;
   logic signed [rcas_pkg::STICK_W-1:0] roll;
   logic signed [rcas_pkg::STICK_W-1:0] pitch;
   logic signed [rcas_pkg::STICK_W-1:0] yaw;
   logic signed [rcas_pkg::STICK_W-1:0] thr;
   logic signed [rcas_pkg::STICK_W-1:0] roll_abs;
   logic signed [rcas_pkg::STICK_W-1:0] pitch_abs;
   logic signed [rcas_pkg::STICK_W-1:0] low_limit;
   logic signed [rcas_pkg::STICK_W-1:0] high_limit;
   logic                                centred;
   logic                                thr_low;

   // Widen sticks and threshold so margins and magnitudes cannot overflow
   assign th    = $signed({3'b000, stick_threshold});
   assign roll  = rcas_pkg::STICK_W'(frame.stick_roll);
   assign pitch = rcas_pkg::STICK_W'(frame.stick_pitch);
   assign yaw   = rcas_pkg::STICK_W'(frame.stick_yaw);
   assign thr   = rcas_pkg::STICK_W'(frame.stick_throttle);

   assign roll_abs   = roll[rcas_pkg::STICK_W-1] ? -roll : roll;
   assign pitch_abs  = pitch[rcas_pkg::STICK_W-1] ? -pitch : pitch;
   assign low_limit  = rcas_pkg::STICK_MIN + th;
   assign high_limit = rcas_pkg::STICK_MAX - th;

   // Classify the stick positions
   assign centred = (roll_abs < th) && (pitch_abs < th);
   assign thr_low = thr < low_limit;

   assign gesture.arm_gesture    = centred && (yaw < low_limit) && thr_low;
   assign gesture.disarm_gesture = centred && (yaw > high_limit) && thr_low;
   assign gesture.thr_above      = thr > low_limit;

endmodule

/* design/rcas_sequencer.sv */
module rcas_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  rcas_pkg::frame_type   frame,
   input  rcas_pkg::gesture_type gesture,
   input  rcas_pkg::cfg_type     cfg,
   output rcas_pkg::result_type  result
);

   typedef enum logic [2:0] {
      ST_PREREQ        = 3'd0,
      ST_WAIT_ARM      = 3'd1,
      ST_WAIT_ENABLE   = 3'd2,
      ST_WAIT_THROTTLE = 3'd3,
      ST_RUNNING       = 3'd4
   } stage_type;

   stage_type            stage_ff;
   stage_type            stage_in;
   logic [31:0]          arm_start_ff;
   logic [31:0]          arm_start_in;
   logic [31:0]          disarm_start_ff;
   logic [31:0]          disarm_start_in;
   logic [1:0]           mode_ff;
   logic [1:0]           mode_in;
   rcas_pkg::result_type result_ff;
   rcas_pkg::result_type result_in;

   logic        arm_req;
   logic        disarm_req;
   logic [1:0]  action;
   logic        done;
   logic        mode_valid;
   logic [31:0] t;

   assign t          = frame.frame_time_ms;
   assign mode_valid = frame.requested_mode != rcas_pkg::MODE_INVALID;

   // Step the arming machine for the frame at the head of the pipe
   always_comb begin
      stage_in        = stage_ff;
      arm_start_in    = arm_start_ff;
      disarm_start_in = disarm_start_ff;
      mode_in         = mode_ff;
      arm_req         = 1'b0;
      disarm_req      = 1'b0;
      action          = rcas_pkg::ACT_NONE;
      done            = 1'b1;

      unique case (stage_ff)
         ST_PREREQ: begin
            if (frame.status_ready) begin
               arm_start_in = t;
               stage_in     = ST_WAIT_ARM;
            end
         end
         ST_WAIT_ARM: begin
            if (frame.rotors_armed) begin
               if (frame.kill_switch) begin
                  arm_start_in = t;
               end else begin
                  stage_in = ST_WAIT_ENABLE;
               end
            end else if (gesture.arm_gesture) begin
               if (rcas_pkg::held_longer(t, arm_start_ff, cfg.arm_hold_ms)) begin
                  arm_req      = 1'b1;
                  arm_start_in = t;
               end else if (!frame.enable_switch || frame.kill_switch ||
                            !frame.prearm_ok) begin
                  arm_start_in = t;
               end
            end else begin
               arm_start_in = t;
            end
         end
         ST_WAIT_ENABLE, ST_WAIT_THROTTLE, ST_RUNNING: begin
            // Common post-arm checks, first match wins
            priority if (!frame.rotors_armed) begin
               arm_start_in = t;
               stage_in     = ST_PREREQ;
            end else if (frame.kill_switch) begin
               disarm_req = 1'b1;
            end else if (!frame.enable_switch) begin
               stage_in        = ST_WAIT_ENABLE;
               disarm_start_in = t;
            end else if (gesture.disarm_gesture) begin
               action = rcas_pkg::ACT_IDLE;
               if (rcas_pkg::held_longer(t, disarm_start_ff, cfg.disarm_hold_ms)) begin
                  disarm_req      = 1'b1;
                  disarm_start_in = t;
               end
            end else begin
               disarm_start_in = t;
               done            = 1'b0;
            end

            // Per-stage work when no common check fired
            if (!done) begin
               unique case (stage_ff)
                  ST_WAIT_ENABLE: begin
                     if (mode_valid && frame.mode_applicable) begin
                        action   = rcas_pkg::ACT_RESET;
                        mode_in  = frame.requested_mode;
                        stage_in = ST_WAIT_THROTTLE;
                     end
                  end
                  ST_WAIT_THROTTLE: begin
                     if (gesture.thr_above) begin
                        disarm_start_in = t;
                        stage_in        = ST_RUNNING;
                     end else begin
                        action = rcas_pkg::ACT_IDLE;
                     end
                  end
                  default: begin
                     if (mode_valid) begin
                        if (frame.requested_mode != mode_ff && frame.mode_applicable) begin
                           action  = rcas_pkg::ACT_RESET;
                           mode_in = frame.requested_mode;
                        end else begin
                           action = rcas_pkg::ACT_UPDATE;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            // Unused stage codes: ignore the frame
            stage_in = stage_ff;
         end
      endcase

      result_in.arm_request       = arm_req;
      result_in.disarm_request    = disarm_req;
      result_in.controller_action = action;
      result_in.active_mode       = mode_in;
      result_in.stage_now         = stage_in;
   end

   // Hold machine state and the result register; advance once per frame
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff        <= ST_PREREQ;
         arm_start_ff    <= 32'd0;
         disarm_start_ff <= 32'd0;
         mode_ff         <= 2'd0;
      end else if (advance) begin
         stage_ff        <= stage_in;
         arm_start_ff    <= arm_start_in;
         disarm_start_ff <= disarm_start_in;
         mode_ff         <= mode_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* design/rc_arming_sequencer_top.sv */
// Stick-arming sequencer for a multirotor: takes one radio-control frame per
// transaction and returns exactly one result transaction per frame, in order.
// A frame enters an input register, is stepped through the five-stage arming
// machine and lands in the result register. A new frame is taken every cycle
// as long as the result side keeps up; the single state update per frame in
// the sequencer sets that rate of one frame per clock. req_stall rises only
// while both the input and the result registers are full and the result is
// stalled. Configuration writes take effect on the next clock and should be
// made while no frame is in flight.
module rc_arming_sequencer_top (
   input  logic               clock,
   input  logic               reset,
   // Configuration port
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   // Frame channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_frame_time_ms,
   input  logic signed [15:0] req_stick_roll,
   input  logic signed [15:0] req_stick_pitch,
   input  logic signed [15:0] req_stick_yaw,
   input  logic signed [15:0] req_stick_throttle,
   input  logic               req_kill_switch,
   input  logic               req_enable_switch,
   input  logic [1:0]         req_requested_mode,
   input  logic               req_status_ready,
   input  logic               req_rotors_armed,
   input  logic               req_prearm_ok,
   input  logic               req_mode_applicable,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_arm_request,
   output logic               rsp_disarm_request,
   output logic [1:0]         rsp_controller_action,
   output logic [1:0]         rsp_active_mode,
   output logic [2:0]         rsp_stage_now
);

   rcas_pkg::cfg_type     cfg;
   rcas_pkg::gesture_type gesture;
   rcas_pkg::result_type  result;
   rcas_pkg::frame_type   frame_ff;
   rcas_pkg::frame_type   frame_in;

   logic pend_valid_ff;
   logic pend_valid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic accept;
   logic advance;
   logic out_free;

   rcas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: result register frees when empty or taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = pend_valid_ff && out_free;
   assign req_stall = pend_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      frame_in.frame_time_ms   = req_frame_time_ms;
      frame_in.stick_roll      = req_stick_roll;
      frame_in.stick_pitch     = req_stick_pitch;
      frame_in.stick_yaw       = req_stick_yaw;
      frame_in.stick_throttle  = req_stick_throttle;
      frame_in.kill_switch     = req_kill_switch;
      frame_in.enable_switch   = req_enable_switch;
      frame_in.requested_mode  = req_requested_mode;
      frame_in.status_ready    = req_status_ready;
      frame_in.rotors_armed    = req_rotors_armed;
      frame_in.prearm_ok       = req_prearm_ok;
      frame_in.mode_applicable = req_mode_applicable;
   end

   // Track occupancy of the input and result registers
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
      end else if (advance) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      if (accept) begin
         frame_ff <= frame_in;
      end
   end

   rcas_gesture u_gesture (
      .frame           (frame_ff),
      .stick_threshold (cfg.stick_threshold),
      .gesture         (gesture)
   );

   rcas_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .frame   (frame_ff),
      .gesture (gesture),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid             = out_valid_ff;
   assign rsp_arm_request       = result.arm_request;
   assign rsp_disarm_request    = result.disarm_request;
   assign rsp_controller_action = result.controller_action;
   assign rsp_active_mode       = result.active_mode;
   assign rsp_stage_now         = result.stage_now;

endmodule

/* design/rcas_checker.sv */
`include "rc_arming_sequencer_top_assert.svh"

module rcas_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_arm_request,
   input logic       rsp_disarm_request,
   input logic [1:0] rsp_controller_action,
   input logic [1:0] rsp_active_mode,
   input logic [2:0] rsp_stage_now
);

   // A stalled result transaction stays put
   `RCAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_arm_request, rsp_disarm_request, rsp_controller_action, rsp_active_mode, rsp_stage_now}), "stalled result changed")

   // Arm and disarm come from disjoint stages
   `RCAS_ASSERT_SAME(a_req_excl, clock, reset, rsp_valid, !(rsp_arm_request && rsp_disarm_request), "arm and disarm requested together")

   // An arm request leaves the machine waiting for arming
   `RCAS_ASSERT_SAME(a_arm_stage, clock, reset, rsp_valid && rsp_arm_request, rsp_stage_now == rcas_pkg::STAGE_WAIT_ARM, "arm request outside wait-for-arming")

   // A controller reset only goes with throttle wait or running
   `RCAS_ASSERT_SAME(a_reset_stage, clock, reset, rsp_valid && (rsp_controller_action == rcas_pkg::ACT_RESET), (rsp_stage_now == rcas_pkg::STAGE_WAIT_THROTTLE) || (rsp_stage_now == rcas_pkg::STAGE_RUNNING), "controller reset in wrong stage")

   // The invalid mode code is never latched
   `RCAS_ASSERT_SAME(a_mode_valid, clock, reset, rsp_valid, rsp_active_mode != rcas_pkg::MODE_INVALID, "invalid mode became active")

endmodule

bind rc_arming_sequencer_top rcas_checker u_rcas_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_arm_request       (rsp_arm_request),
   .rsp_disarm_request    (rsp_disarm_request),
   .rsp_controller_action (rsp_controller_action),
   .rsp_active_mode       (rsp_active_mode),
   .rsp_stage_now         (rsp_stage_now)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import rcas_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;

   // Stages of the arming machine as the predictor tracks them
   typedef enum logic [2:0] {
      STG_PREREQ,
      STG_WAIT_ARM,
      STG_WAIT_ENABLE,
      STG_WAIT_THROTTLE,
      STG_RUNNING
   } stage_e;

   logic clock;
   logic reset = 1'b1;

   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_STICK_THRESHOLD;
   logic [15:0] csr_wdata = '0;

   logic      req_valid = 1'b0;
   logic      req_stall;
   frame_type offered = '0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_arm_request;
   logic       rsp_disarm_request;
   logic [1:0] rsp_controller_action;
   logic [1:0] rsp_active_mode;
   logic [2:0] rsp_stage_now;

   // Frames waiting to be offered and results the block still owes
   frame_type  frames_pending [$];
   result_type results_due [$];

   int frames_queued = 0;
   int frames_taken = 0;
   int results_seen = 0;
   int mismatches = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int sender_gap_pct = 10;
   int receiver_gap_pct = 88;

   // Predictor copy of the registers and the sequencer state
   cfg_type     cfg_now = '{THRESHOLD_RESET, ARM_HOLD_RESET, DISARM_HOLD_RESET};
   stage_e      seq_stage = STG_PREREQ;
   logic [31:0] arm_since = '0;
   logic [31:0] disarm_since = '0;
   logic [1:0]  live_mode = '0;

   // Stimulus generator state
   logic [31:0] gen_time = '0;
   int          gen_thr = 1638;
   logic        random_part = 1'b0;

   rc_arming_sequencer_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_frame_time_ms     (offered.frame_time_ms),
      .req_stick_roll        (offered.stick_roll),
      .req_stick_pitch       (offered.stick_pitch),
      .req_stick_yaw         (offered.stick_yaw),
      .req_stick_throttle    (offered.stick_throttle),
      .req_kill_switch       (offered.kill_switch),
      .req_enable_switch     (offered.enable_switch),
      .req_requested_mode    (offered.requested_mode),
      .req_status_ready      (offered.status_ready),
      .req_rotors_armed      (offered.rotors_armed),
      .req_prearm_ok         (offered.prearm_ok),
      .req_mode_applicable   (offered.mode_applicable),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_arm_request       (rsp_arm_request),
      .rsp_disarm_request    (rsp_disarm_request),
      .rsp_controller_action (rsp_controller_action),
      .rsp_active_mode       (rsp_active_mode),
      .rsp_stage_now         (rsp_stage_now)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Gesture hold check: elapsed time modulo 2^32 strictly above the hold
   function automatic logic hold_expired(logic [31:0] now, logic [31:0] since,
                                         logic [15:0] hold);
      logic [31:0] elapsed;
      elapsed = now - since;
      return elapsed > {16'd0, hold};
   endfunction

   // Advance the sequencer by one frame and return the result it owes
   function automatic result_type step_sequencer(frame_type f);
      result_type r;
      logic [31:0] t;
      int   th, roll, pitch, yaw, thr;
      logic centred, thr_low, arm_g, disarm_g, mode_ok, settled;
      t = f.frame_time_ms;
      th = int'(cfg_now.stick_threshold);
      roll = $signed(f.stick_roll);
      pitch = $signed(f.stick_pitch);
      yaw = $signed(f.stick_yaw);
      thr = $signed(f.stick_throttle);
      if (roll < 0) roll = -roll;
      if (pitch < 0) pitch = -pitch;
      centred = (roll < th) && (pitch < th);
      thr_low = thr < int'(STICK_MIN) + th;
      arm_g = centred && (yaw < int'(STICK_MIN) + th) && thr_low;
      disarm_g = centred && (yaw > int'(STICK_MAX) - th) && thr_low;
      mode_ok = f.requested_mode != MODE_INVALID;
      r = '0;
      r.controller_action = ACT_NONE;

      case (seq_stage)
         STG_PREREQ: begin
            if (f.status_ready) begin
               arm_since = t;
               seq_stage = STG_WAIT_ARM;
            end
         end
         STG_WAIT_ARM: begin
            if (f.rotors_armed) begin
               if (f.kill_switch) arm_since = t;
               else seq_stage = STG_WAIT_ENABLE;
            end else if (arm_g) begin
               if (hold_expired(t, arm_since, cfg_now.arm_hold_ms)) begin
                  r.arm_request = 1'b1;
                  arm_since = t;
               end else if (!f.enable_switch || f.kill_switch || !f.prearm_ok) begin
                  arm_since = t;
               end
            end else begin
               arm_since = t;
            end
         end
         default: begin
            // common checks of the armed stages
            settled = 1'b1;
            if (!f.rotors_armed) begin
               arm_since = t;
               seq_stage = STG_PREREQ;
            end else if (f.kill_switch) begin
               r.disarm_request = 1'b1;
            end else if (!f.enable_switch) begin
               seq_stage = STG_WAIT_ENABLE;
               disarm_since = t;
            end else if (disarm_g) begin
               r.controller_action = ACT_IDLE;
               if (hold_expired(t, disarm_since, cfg_now.disarm_hold_ms)) begin
                  r.disarm_request = 1'b1;
                  disarm_since = t;
               end
            end else begin
               disarm_since = t;
               settled = 1'b0;
            end

            // stage-specific work
            if (!settled) begin
               case (seq_stage)
                  STG_WAIT_ENABLE: begin
                     if (mode_ok && f.mode_applicable) begin
                        r.controller_action = ACT_RESET;
                        live_mode = f.requested_mode;
                        seq_stage = STG_WAIT_THROTTLE;
                     end
                  end
                  STG_WAIT_THROTTLE: begin
                     if (thr > int'(STICK_MIN) + th) begin
                        disarm_since = t;
                        seq_stage = STG_RUNNING;
                     end else begin
                        r.controller_action = ACT_IDLE;
                     end
                  end
                  default: begin
                     if (mode_ok) begin
                        if (f.requested_mode != live_mode && f.mode_applicable) begin
                           r.controller_action = ACT_RESET;
                           live_mode = f.requested_mode;
                        end else begin
                           r.controller_action = ACT_UPDATE;
                        end
                     end
                  end
               endcase
            end
         end
      endcase

      r.active_mode = live_mode;
      r.stage_now = seq_stage;
      return r;
   endfunction

   // Stick value near a target, crossing the threshold margin now and then
   function automatic logic signed [15:0] stick_near(int centre);
      int v, off;
      if ($urandom_range(99) < 15) begin
         v = ($urandom_range(1) == 0) ? centre - gen_thr : centre + gen_thr;
      end else begin
         off = $urandom_range(2 * gen_thr + 2);
         v = centre + off - (gen_thr + 1);
      end
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return 16'(v);
   endfunction

   // Stick value anywhere, mostly inside the nominal range
   function automatic logic signed [15:0] stick_any();
      int v;
      if ($urandom_range(99) < 20) return 16'($urandom);
      v = $urandom_range(32768);
      return 16'(v - 16384);
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      f.frame_time_ms = '0;
      f.stick_roll = stick_any();
      f.stick_pitch = stick_any();
      f.stick_yaw = stick_any();
      f.stick_throttle = stick_any();
      f[7:0] = 8'($urandom);
      return f;
   endfunction

   function automatic frame_type with_gesture(frame_type f, int yaw_end);
      f.stick_roll = stick_near(0);
      f.stick_pitch = stick_near(0);
      f.stick_yaw = stick_near(yaw_end);
      f.stick_throttle = stick_near(int'(STICK_MIN));
      return f;
   endfunction

   // Stamp a frame, in the random part flip one of its flag bits now and then, and queue it
   task automatic push_frame(frame_type f);
      int pick;
      if (random_part && $urandom_range(99) < 4)
         f[7:0] = f[7:0] ^ (8'd1 << $urandom_range(7));
      f.frame_time_ms = gen_time;
      frames_pending.push_back(f);
      frames_queued++;
      pick = $urandom_range(99);
      if (!random_part) gen_time += 10;
      else if (pick < 60) gen_time += $urandom_range(40);
      else if (pick < 90) gen_time += $urandom_range(70000);
      else if (pick < 98) gen_time += $urandom_range(1500);
      else gen_time = $urandom;
   endtask

   // One flight: ready, arm, enable, throttle up, fly, disarm; now and then only random frames
   task automatic add_session();
      frame_type f;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(10, 20)) push_frame(random_frame());
         return;
      end
      f = random_frame();
      f.status_ready = 1'b0;
      repeat ($urandom_range(2)) push_frame(f);
      f.status_ready = 1'b1;
      f.rotors_armed = 1'b0;
      push_frame(f);

      // hold the arm gesture
      repeat ($urandom_range(1, 6)) begin
         f = with_gesture(f, int'(STICK_MIN));
         f.enable_switch = $urandom_range(9) != 0;
         f.kill_switch = $urandom_range(9) == 0;
         f.prearm_ok = $urandom_range(9) != 0;
         push_frame(f);
      end

      // vehicle reports armed, kill briefly on at times
      f.rotors_armed = 1'b1;
      f.enable_switch = 1'b1;
      f.kill_switch = $urandom_range(3) == 0;
      push_frame(f);
      f.kill_switch = 1'b0;
      push_frame(f);

      // select a mode
      repeat ($urandom_range(1, 3)) begin
         f.requested_mode = 2'($urandom_range(3));
         f.mode_applicable = $urandom_range(9) < 7;
         push_frame(f);
      end
      f.requested_mode = 2'($urandom_range(2));
      f.mode_applicable = 1'b1;
      push_frame(f);

      // throttle low, then up
      repeat ($urandom_range(2)) begin
         f.stick_throttle = stick_near(int'(STICK_MIN));
         push_frame(f);
      end
      f.stick_throttle = 16'($urandom_range(16384));
      push_frame(f);

      // fly
      repeat ($urandom_range(3, 12)) begin
         f.stick_roll = stick_any();
         f.stick_pitch = stick_any();
         f.stick_yaw = stick_any();
         f.stick_throttle = stick_any();
         f.requested_mode = 2'($urandom_range(3));
         f.mode_applicable = $urandom_range(9) < 8;
         f.kill_switch = $urandom_range(19) == 0;
         f.enable_switch = $urandom_range(19) != 0;
         push_frame(f);
      end
      f.kill_switch = 1'b0;
      f.enable_switch = 1'b1;

      // hold the disarm gesture, then the vehicle reports disarmed
      repeat ($urandom_range(1, 6)) begin
         f = with_gesture(f, int'(STICK_MAX));
         push_frame(f);
      end
      f.rotors_armed = 1'b0;
      push_frame(f);
   endtask

   task automatic program_regs(cfg_type c);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_STICK_THRESHOLD;
      csr_wdata <= 16'(c.stick_threshold);
      @(posedge clock);
      csr_index <= REG_ARM_HOLD_MS;
      csr_wdata <= c.arm_hold_ms;
      @(posedge clock);
      csr_index <= REG_DISARM_HOLD_MS;
      csr_wdata <= c.disarm_hold_ms;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_now = c;
      gen_thr = int'(c.stick_threshold);
   endtask

   // Wait until every frame is taken and every result is back
   task automatic wait_drained();
      while (!(frames_taken == frames_queued && results_due.size() == 0))
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(string field, logic [2:0] want, logic [2:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Sender: offer queued frames, with random gaps
   always @(posedge clock) begin
      logic offering;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         // retire the accepted transaction and record the result it owes
         if (req_valid && !req_stall) begin
            results_due.push_back(step_sequencer(offered));
            frames_taken++;
            offering = 1'b0;
         end
         // offer the next frame unless this cycle is a gap
         if (!offering && frames_pending.size() > 0 &&
             $urandom_range(99) >= sender_gap_pct) begin
            offered <= frames_pending.pop_front();
            offering = 1'b1;
         end
         req_valid <= offering;
      end
   end

   // Receiver: check each result transaction, stall at random
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: result transaction with none expected, actual %h", $time,
                        {rsp_arm_request, rsp_disarm_request, rsp_controller_action,
                         rsp_active_mode, rsp_stage_now});
            end else begin
               want = results_due.pop_front();
               check_field("arm_request", 3'(want.arm_request), 3'(rsp_arm_request));
               check_field("disarm_request", 3'(want.disarm_request),
                           3'(rsp_disarm_request));
               check_field("controller_action", 3'(want.controller_action),
                           3'(rsp_controller_action));
               check_field("active_mode", 3'(want.active_mode), 3'(rsp_active_mode));
               check_field("stage_now", want.stage_now, rsp_stage_now);
            end
            // hold off for a long stretch now and then so the block backs up
            if (results_seen % 700 == 350) hold_left = $urandom_range(60, 120);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_gap_pct);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      frame_type f;
      cfg_type   plan [6];
      int        target;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under a short arm hold
      program_regs('{15'd1638, 16'd100, 16'd1000});
      f = '0;
      f.stick_roll = 16'sh7fff;
      f.stick_pitch = 16'sh8000;
      f.stick_yaw = 16'sd16384;
      f.stick_throttle = -16'sd16384;
      gen_time = 32'hffff_ff00;
      push_frame(f);                         // not ready: stay
      f.status_ready = 1'b1;
      push_frame(f);                         // ready: wait for arming
      f.stick_roll = '0;
      f.stick_pitch = '0;
      f.stick_yaw = -16'sd16384;
      f.enable_switch = 1'b1;
      f.prearm_ok = 1'b1;
      push_frame(f);                         // arm gesture, hold not over
      gen_time = 32'h0000_0050;
      push_frame(f);                         // hold over across the wrap: arm
      f.prearm_ok = 1'b0;
      push_frame(f);                         // pre-arm failed: restart hold
      f.rotors_armed = 1'b1;
      f.kill_switch = 1'b1;
      push_frame(f);                         // armed with kill on: stay
      f.kill_switch = 1'b0;
      f.requested_mode = MODE_INVALID;
      f.mode_applicable = 1'b1;
      push_frame(f);                         // armed: wait for enable
      push_frame(f);                         // invalid mode: no action
      f.requested_mode = 2'd1;
      f.mode_applicable = 1'b0;
      push_frame(f);                         // mode not applicable: wait
      f.mode_applicable = 1'b1;
      push_frame(f);                         // reset into stabilize
      push_frame(f);                         // throttle low: idle update
      f.stick_throttle = '0;
      push_frame(f);                         // throttle up: running
      f.stick_roll = 16'sh7fff;
      f.stick_pitch = 16'sh8000;
      f.stick_yaw = 16'sh7fff;
      push_frame(f);                         // sticks out of range: update
      f.requested_mode = 2'd2;
      f.mode_applicable = 1'b0;
      push_frame(f);                         // keep old mode
      f.mode_applicable = 1'b1;
      push_frame(f);                         // switch to loiter
      f.requested_mode = MODE_INVALID;
      push_frame(f);                         // invalid mode while running
      f.kill_switch = 1'b1;
      push_frame(f);                         // kill: disarm request
      f.kill_switch = 1'b0;
      f.enable_switch = 1'b0;
      push_frame(f);                         // enable off: back to wait enable
      f.enable_switch = 1'b1;
      f.requested_mode = 2'd0;
      push_frame(f);                         // reset into acrobat
      push_frame(f);                         // running again
      f.stick_roll = '0;
      f.stick_pitch = '0;
      f.stick_yaw = 16'sd16384;
      f.stick_throttle = -16'sd16384;
      push_frame(f);                         // disarm gesture, hold not over
      gen_time += 2000;
      push_frame(f);                         // disarm hold over
      f.rotors_armed = 1'b0;
      push_frame(f);                         // disarmed: prerequisites
      push_frame(f);                         // ready again
      f.stick_yaw = -16'sd14746;
      push_frame(f);                         // yaw exactly at the margin

      // Random flights, register settings and idling per phase
      plan[0] = '{15'd1638, 16'd200, 16'd300};
      plan[1] = '{15'd16384, 16'd65535, 16'd65535};
      plan[2] = '{15'd0, 16'd0, 16'd0};
      plan[3] = '{15'd4000, 16'd0, 16'd65535};
      plan[4] = '{15'd1, 16'd1000, 16'd1000};
      plan[5] = '{15'd8000, 16'd50, 16'd20};
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         program_regs(plan[ph]);
         sender_gap_pct = (ph < 2) ? 10 : (ph < 4) ? 88 : 0;
         receiver_gap_pct = (ph < 2) ? 88 : (ph < 4) ? 10 : 0;
         random_part = 1'b1;
         target = frames_queued + 300;
         while (frames_queued < target) add_session();
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/rcas_pkg.sv
design/rcas_csr.sv
design/rcas_gesture.sv
design/rcas_sequencer.sv
design/rc_arming_sequencer_top.sv
design/rcas_checker.sv
tb/tb_top.sv
